>>> rtl/kmp_pkg.sv
// Shared types and constants for the stream matcher.
// Used by kmp_cell and kmp_stream_matcher; depends on nothing.
package kmp_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int LENGTH_WIDTH    = 5;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LOW    = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_HIGH   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PATTERN_LENGTH = 2'd2;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic                  advance;   // a text byte is taken this cycle
      logic                  flush;     // pattern changed: drop partial matches
      logic [BYTE_WIDTH-1:0] text_byte;
   } kmp_ctl_type;

endpackage

>>> rtl/kmp_cell.sv
// One cell of the matcher chain: holds one pattern position's partial-match bit.
// Depends on kmp_pkg for the control struct and byte width.
module kmp_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  kmp_pkg::kmp_ctl_type             ctl,
   input  logic [kmp_pkg::BYTE_WIDTH-1:0]   pattern_byte,
   input  logic                             prev_hit,
   output logic                             hit,
   output logic                             active
);
   import kmp_pkg::*;

   logic active_ff;
   logic active_in;

   // the prefix up to this cell matches if the shorter prefix matched one byte ago
   assign hit = prev_hit & (pattern_byte == ctl.text_byte);

   always_comb begin
      active_in = active_ff;
      if (ctl.flush) begin
         active_in = 1'b0;
      end else if (ctl.advance) begin
         active_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule

>>> rtl/kmp_stream_matcher.sv
// Top level of the pattern matcher: configuration registers, cell chain, output register.
// Depends on kmp_pkg and kmp_cell.

// Finds every occurrence, overlapping ones included, of a pattern of 1 to PATTERN_MAX bytes
// in a byte stream. Cell k of the chain remembers whether the text so far ends with pattern
// bytes 0..k; all cells update together on each byte, so one byte is taken every cycle that
// is not stalled, and its result appears in the output register in the next cycle. The
// output register frees itself in the cycle it is read, so the input stalls only while
// rsp_ready is low. A result carries match_found and the zero-based start index of the
// occurrence (0 when no match). new_text restarts the position count and drops partial
// matches before its byte; a write to a known configuration register also drops partial
// matches but keeps the position count, and a write to an unknown index changes nothing.
module kmp_stream_matcher #(
   parameter int PATTERN_MAX    = 16,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [kmp_pkg::BYTE_WIDTH-1:0]        req_text_byte,
   input  logic                                  req_new_text,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_match_found,
   output logic [31:0]                           rsp_match_start,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kmp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [kmp_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);
   import kmp_pkg::*;

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [CSR_DATA_WIDTH-1:0] pattern_low_ff,  pattern_low_in;
   logic [CSR_DATA_WIDTH-1:0] pattern_high_ff, pattern_high_in;
   logic [IDX_W-1:0]          last_ff,         last_in;
   logic [POSITION_WIDTH-1:0] position_ff,     position_in;
   logic                      rsp_valid_ff,    rsp_valid_in;
   logic                      rsp_found_ff,    rsp_found_in;
   logic [31:0]               rsp_start_ff,    rsp_start_in;

   logic                      req_accept;
   logic                      csr_accept;
   logic                      csr_known;
   logic [POSITION_WIDTH-1:0] index_now;
   logic [POSITION_WIDTH-1:0] start_index;
   logic [LENGTH_WIDTH-1:0]   length_raw;
   logic [IDX_W-1:0]          last_new;
   kmp_ctl_type               ctl;
   logic [PATTERN_MAX-1:0]    prev_hit;
   logic [PATTERN_MAX-1:0]    hit;
   logic [PATTERN_MAX-1:0]    active;

   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid & csr_ready;
   assign req_ready  = ~rsp_valid_ff | rsp_ready;
   assign req_accept = req_valid & req_ready;

   // only a write to a known register changes the pattern
   assign csr_known = csr_index inside {REG_PATTERN_LOW, REG_PATTERN_HIGH, REG_PATTERN_LENGTH};

   assign ctl.advance   = req_accept;
   assign ctl.flush     = csr_accept & csr_known;
   assign ctl.text_byte = req_text_byte;

   // clamp the length to 1..PATTERN_MAX and keep the index of its last byte
   assign length_raw = csr_wdata[LENGTH_WIDTH-1:0];
   always_comb begin
      if (length_raw == '0) begin
         last_new = '0;
      end else if (int'(length_raw) > PATTERN_MAX) begin
         last_new = IDX_W'(PATTERN_MAX - 1);
      end else begin
         last_new = IDX_W'(length_raw - LENGTH_WIDTH'(1));
      end
   end

   always_comb begin
      pattern_low_in  = pattern_low_ff;
      pattern_high_in = pattern_high_ff;
      last_in         = last_ff;
      if (csr_accept) begin
         case (csr_index)
            REG_PATTERN_LOW:    pattern_low_in  = csr_wdata;
            REG_PATTERN_HIGH:   pattern_high_in = csr_wdata;
            REG_PATTERN_LENGTH: last_in         = last_new;
            default:            last_in         = last_ff;
         endcase
      end
   end

   generate
      for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
         logic [BYTE_WIDTH-1:0] pattern_byte;
         if (k < 8) begin : g_low
            assign pattern_byte = pattern_low_ff[BYTE_WIDTH*k +: BYTE_WIDTH];
         end else begin : g_high
            assign pattern_byte = pattern_high_ff[BYTE_WIDTH*(k-8) +: BYTE_WIDTH];
         end
         // the first cell always has an empty prefix behind it
         if (k == 0) begin : g_head
            assign prev_hit[k] = 1'b1;
         end else begin : g_body
            assign prev_hit[k] = active[k-1] & ~req_new_text;
         end
         kmp_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .pattern_byte (pattern_byte),
            .prev_hit     (prev_hit[k]),
            .hit          (hit[k]),
            .active       (active[k])
         );
      end
   endgenerate

   assign index_now   = req_new_text ? '0 : position_ff;
   assign start_index = index_now - POSITION_WIDTH'(last_ff);

   always_comb begin
      position_in  = position_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_start_in = rsp_start_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept) begin
         position_in  = index_now + POSITION_WIDTH'(1);
         rsp_valid_in = 1'b1;
         rsp_found_in = hit[last_ff];
         rsp_start_in = hit[last_ff] ? 32'(start_index) : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         last_ff         <= '0;
         position_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pattern_low_ff  <= pattern_low_in;
         pattern_high_ff <= pattern_high_in;
         last_ff         <= last_in;
         position_ff     <= position_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_start_ff <= rsp_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_found = rsp_found_ff;
   assign rsp_match_start = rsp_start_ff;

endmodule
